// ===== rtl/c80alu_pkg.sv =====
// Package for the 8080/8085 ALU block: operation codes, flag bit positions,
// constants and the structs passed between the top level and the ALU core.
// Depends on nothing.
`default_nettype none

package c80alu_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PAIR_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 4'd0,
      OP_ADC      = 4'd1,
      OP_SUB      = 4'd2,
      OP_SBB      = 4'd3,
      OP_CMP      = 4'd4,
      OP_AND      = 4'd5,
      OP_OR       = 4'd6,
      OP_XOR      = 4'd7,
      OP_INC      = 4'd8,
      OP_DEC      = 4'd9,
      OP_DAA      = 4'd10,
      OP_PAIR_ADD = 4'd11
   } op_type;

   // Flag byte bit positions.
   localparam int unsigned F_S  = 7;
   localparam int unsigned F_Z  = 6;
   localparam int unsigned F_X5 = 5;
   localparam int unsigned F_H  = 4;
   localparam int unsigned F_X3 = 3;
   localparam int unsigned F_P  = 2;
   localparam int unsigned F_V  = 1;
   localparam int unsigned F_C  = 0;

   localparam logic [3:0]        NIBBLE_MAX = 4'hF;
   localparam logic [3:0]        DEC_DIGIT_MAX = 4'd9;
   localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;
   localparam logic [3:0]        DAA_ADJ    = 4'h6;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   acc;
      logic [BYTE_W-1:0]   operand;
      logic [BYTE_W-1:0]   flags_in;
      logic [PAIR_W-1:0]   pair_acc;
      logic [PAIR_W-1:0]   pair_operand;
   } alu_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   result;
      logic [BYTE_W-1:0]   flags_out;
      logic [PAIR_W-1:0]   pair_result;
   } alu_out_type;

   // Sign, zero and even-parity flags of a byte, in their flag positions.
   function automatic logic [BYTE_W-1:0] szp(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] f;
      f      = '0;
      f[F_S] = v[7];
      f[F_Z] = (v == '0);
      f[F_P] = ~^v;
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/c80alu_core.sv =====
// Combinational 8080/8085 ALU: result, flag byte and pair sum for one operation.
// Depends on c80alu_pkg.
`default_nettype none

module c80alu_core
   import c80alu_pkg::*;
(
   input  wire logic        variant,
   input  wire alu_in_type  alu_in,
   output alu_out_type      alu_out
);

   logic [BYTE_W-1:0] a, b, fi;
   logic [BYTE_W:0]   sum9, dif9;
   logic              cin;
   logic [BYTE_W-1:0] and_v, or_v, xor_v, inc_v, dec_v;
   logic              daa_lo, daa_hi, daa_sub;
   logic [BYTE_W-1:0] daa_corr, daa_v;
   logic [PAIR_W:0]   pair17;

   always_comb begin
      a   = alu_in.acc;
      b   = alu_in.operand;
      fi  = alu_in.flags_in;
      cin = ((alu_in.op == OP_ADC) || (alu_in.op == OP_SBB)) && fi[F_C];

      sum9 = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, cin};
      dif9 = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, cin};

      and_v = a & b;
      or_v  = a | b;
      xor_v = a ^ b;
      inc_v = b + 8'd1;
      dec_v = b - 8'd1;

      // Decimal adjust: the 8085 subtracts the corrections when flag V of flags_in is set.
      daa_lo   = fi[F_H] || (a[3:0] > DEC_DIGIT_MAX);
      daa_hi   = fi[F_C] || (a > DAA_LIMIT);
      daa_sub  = variant && fi[F_V];
      daa_corr = {(daa_hi ? DAA_ADJ : 4'h0), (daa_lo ? DAA_ADJ : 4'h0)};
      daa_v    = daa_sub ? (a - daa_corr) : (a + daa_corr);

      pair17 = {1'b0, alu_in.pair_acc} + {1'b0, alu_in.pair_operand};

      alu_out.result      = a;
      alu_out.flags_out   = fi;
      alu_out.pair_result = alu_in.pair_acc;

      case (alu_in.op)
         OP_ADD, OP_ADC: begin
            alu_out.result         = sum9[BYTE_W-1:0];
            alu_out.flags_out      = szp(sum9[BYTE_W-1:0]);
            alu_out.flags_out[F_H] = a[4] ^ b[4] ^ sum9[4];
            alu_out.flags_out[F_V] = 1'b1;
            alu_out.flags_out[F_C] = sum9[BYTE_W];
         end
         OP_SUB, OP_SBB, OP_CMP: begin
            alu_out.result         = (alu_in.op == OP_CMP) ? a : dif9[BYTE_W-1:0];
            alu_out.flags_out      = szp(dif9[BYTE_W-1:0]);
            alu_out.flags_out[F_H] = ~(a[4] ^ b[4] ^ dif9[4]);
            alu_out.flags_out[F_V] = 1'b1;
            alu_out.flags_out[F_C] = dif9[BYTE_W];
         end
         OP_AND: begin
            alu_out.result         = and_v;
            alu_out.flags_out      = szp(and_v);
            alu_out.flags_out[F_H] = variant | a[3] | b[3];
         end
         OP_OR: begin
            alu_out.result    = or_v;
            alu_out.flags_out = szp(or_v);
         end
         OP_XOR: begin
            alu_out.result    = xor_v;
            alu_out.flags_out = szp(xor_v);
         end
         OP_INC: begin
            alu_out.result         = inc_v;
            alu_out.flags_out      = szp(inc_v);
            alu_out.flags_out[F_H] = (b[3:0] == NIBBLE_MAX);
            alu_out.flags_out[F_C] = fi[F_C];
         end
         OP_DEC: begin
            alu_out.result         = dec_v;
            alu_out.flags_out      = szp(dec_v);
            alu_out.flags_out[F_H] = (b[3:0] != 4'h0);
            alu_out.flags_out[F_V] = 1'b1;
            alu_out.flags_out[F_C] = fi[F_C];
         end
         OP_DAA: begin
            alu_out.result          = daa_v;
            alu_out.flags_out       = szp(daa_v);
            alu_out.flags_out[F_X5] = a[5];
            alu_out.flags_out[F_H]  = a[4] ^ daa_v[4];
            alu_out.flags_out[F_X3] = a[3];
            alu_out.flags_out[F_V]  = fi[F_V];
            alu_out.flags_out[F_C]  = fi[F_C] | (a > DAA_LIMIT);
         end
         OP_PAIR_ADD: begin
            alu_out.pair_result    = pair17[PAIR_W-1:0];
            alu_out.flags_out[F_C] = pair17[PAIR_W];
         end
         default: begin
            alu_out.result = a;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/cpu8080_alu_flags.sv =====
// Top level of the 8080/8085 ALU block: stream handshake, variant register,
// input and result registers around the ALU core. Depends on c80alu_pkg, c80alu_core.
`default_nettype none

// Each transfer on the request channel carries one ALU operation and returns
// exactly one transfer on the response channel, in order. An item passes
// through the input register and then the result register, with the ALU
// core's adders and flag logic between them. A new item can be taken in
// every cycle, so the sustained rate is one item per cycle while the response
// side keeps taking transfers; when it stalls, the input register takes one
// more item only if it is empty, and after that the request side stalls.
// The variant register (csr_wdata) selects 8080 rules when 0 and 8085 rules
// when 1; it resets to 0 and should be written only while no items are in
// flight.

module cpu8080_alu_flags
   import c80alu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_wdata,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata, from bit 0 up: acc[7:0], operand[15:8], flags_in[23:16],
   // pair_acc[39:24], pair_operand[55:40]
   input  wire logic [55:0] req_tdata,
   // tuser: op[3:0]
   input  wire logic [3:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata, from bit 0 up: result[7:0], flags_out[15:8], pair_result[31:16]
   output logic [31:0]      rsp_tdata
);

   logic        variant_ff, variant_in;
   logic        s1_valid_ff, s1_valid_in;
   alu_in_type  s1_data_ff, s1_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   alu_out_type rsp_data_ff, rsp_data_in;
   alu_out_type core_out;
   logic        advance;

   // The result register may be refilled when it is empty or its transfer
   // completes this cycle; the input register may be refilled when it is empty or the result register may be.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      variant_in = csr_we ? csr_wdata[0] : variant_ff;

      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_tready) begin
         s1_valid_in             = req_tvalid;
         s1_data_in.op           = op_type'(req_tuser);
         s1_data_in.acc          = req_tdata[7:0];
         s1_data_in.operand      = req_tdata[15:8];
         s1_data_in.flags_in     = req_tdata[23:16];
         s1_data_in.pair_acc     = req_tdata[39:24];
         s1_data_in.pair_operand = req_tdata[55:40];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = core_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         variant_ff   <= variant_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   c80alu_core u_core (
      .variant (variant_ff),
      .alu_in  (s1_data_ff),
      .alu_out (core_out)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.pair_result, rsp_data_ff.flags_out, rsp_data_ff.result};

endmodule

`default_nettype wire
